[src/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
// Self-contained; no dependencies. Bodies vanish under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/sfs_pkg.sv]
// Package for the sprite frame sequencer: widths, codes, types.
// No dependencies.
package sfs_pkg;

    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_TIME_BITS  = 16;
    localparam int TABLE_DEPTH    = 16;

    localparam int ELAPSED_W = 16;
    localparam int ADDR_W    = 4;
    localparam int DELAY_W   = 16;
    localparam int ALPHA_W   = 8;
    localparam int COUNT_W   = 5;
    localparam int FRAME_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int PROD_W    = ALPHA_W + DELAY_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG   = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_CUR,
        ST_STEP,
        ST_RD_NEW,
        ST_MUL,
        ST_DIV,
        ST_ALPHA,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [ALPHA_W-1:0] alpha_start;
        logic [ALPHA_W-1:0] alpha_end;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic write;
        logic step;
        logic mul;
        logic div_step;
        logic alpha;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic req_load;
        logic enable;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

[src/sfs_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit ALPHA_W bits.
// Depends on sfs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [sfs_pkg::PROD_W-1:0]  i_dividend,
    input  logic                        i_step,
    input  logic [sfs_pkg::DELAY_W-1:0] i_divisor,
    output logic [sfs_pkg::ALPHA_W-1:0] o_quot,
    output logic                        o_last
);
    import sfs_pkg::*;

    localparam int CNT_W = $clog2(ALPHA_W);

    logic [PROD_W-1:0]  r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [DELAY_W:0]   trial;
    logic [DELAY_W:0]   diff;
    logic               ge;
    logic [DELAY_W-1:0] rem_n;

    always_comb begin
        trial = {r_acc[PROD_W-1:ALPHA_W], r_acc[ALPHA_W-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
        rem_n = ge ? diff[DELAY_W-1:0] : trial[DELAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= i_dividend;
        end else if (i_step) begin
            r_acc <= {rem_n, r_acc[ALPHA_W-2:0], ge};
        end
    end

    assign o_quot = r_acc[ALPHA_W-1:0];
    assign o_last = &r_cnt;

    // partial remainder stays below the divisor throughout
    `SFS_ASSERT(a_rem_below_div, i_clk, i_rst_n, (i_step && i_divisor != '0) |-> (r_acc[PROD_W-1:ALPHA_W] < i_divisor), "sfs_div: remainder overflow")

endmodule

[src/sfs_dp.sv]
// Datapath: config registers, frame table memory, frame/time state, alpha math, output register.
// Depends on sfs_pkg, sfs_div and assert_macros.svh.
`include "assert_macros.svh"
module sfs_dp #(
    parameter int MAX_FRAMES = sfs_pkg::DEF_MAX_FRAMES,
    parameter int TIME_BITS  = sfs_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sfs_pkg::t_cmd                  i_cmd,
    output sfs_pkg::t_status               o_status,
    input  logic                           i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_req_type,
    input  logic [sfs_pkg::ELAPSED_W-1:0]  i_elapsed_ms,
    input  logic [sfs_pkg::ADDR_W-1:0]     i_frame_addr,
    input  logic [sfs_pkg::DELAY_W-1:0]    i_frame_delay,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha_start,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha_end,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [sfs_pkg::FRAME_W-1:0]    o_frame_index,
    output logic [sfs_pkg::ALPHA_W-1:0]    o_alpha,
    output logic                           o_cycle_done,
    output logic                           o_running_backward
);
    import sfs_pkg::*;

    localparam int LIM   = (MAX_FRAMES < TABLE_DEPTH) ? MAX_FRAMES : TABLE_DEPTH;
    localparam int AW    = $clog2(LIM);
    localparam int TW    = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
    localparam logic [COUNT_W-1:0] LIM_C = COUNT_W'(LIM);
    localparam logic [TW:0] TMAX = (TW+1)'({TIME_BITS{1'b1}});

    // configuration
    logic               r_enable;
    logic [COUNT_W-1:0] r_frame_count;
    logic               r_ping_pong;

    // captured transaction
    logic                 r_req_type;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [ADDR_W-1:0]    r_addr;
    t_entry               r_wr_entry;

    // sequencer state
    logic [TIME_BITS-1:0] r_time;
    logic [FRAME_W-1:0]   r_cur;
    logic                 r_back;
    logic [ALPHA_W-1:0]   r_shown;
    logic                 r_done;

    // table
    t_entry mem [LIM];
    t_entry r_rd;

    // alpha terms
    logic [ALPHA_W-1:0] r_s;
    logic               r_up;
    logic               r_trivial;
    logic [DELAY_W-1:0] r_dvs;

    // output register
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_frame;
    logic [ALPHA_W-1:0] r_out_alpha;
    logic               r_out_done;
    logic               r_out_back;

    logic [COUNT_W-1:0]   n_cnt;
    logic [TW:0]          sum;
    logic [TW:0]          sat;
    logic                 expire;
    logic                 at_end;
    logic [FRAME_W-1:0]   n_cur;
    logic                 n_back;
    logic [TIME_BITS-1:0] n_time;
    logic [ALPHA_W-1:0]   s_sel;
    logic [ALPHA_W-1:0]   e_sel;
    logic [ALPHA_W-1:0]   diff;
    logic [TW-1:0]        t_ext;
    logic [DELAY_W-1:0]   t_cl;
    logic [PROD_W-1:0]    prod;
    logic [ALPHA_W-1:0]   quot;
    logic                 div_last;
    logic                 wr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_frame_count <= COUNT_W'(1);
            r_ping_pong   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLE:      r_enable      <= i_cfg_wdata[0];
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata;
                CFG_PING_PONG:   r_ping_pong   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type             <= i_req_type;
            r_elapsed              <= i_elapsed_ms;
            r_addr                 <= i_frame_addr;
            r_wr_entry.delay       <= i_frame_delay;
            r_wr_entry.alpha_start <= i_alpha_start;
            r_wr_entry.alpha_end   <= i_alpha_end;
        end
    end

    assign wr_ok = {1'b0, r_addr} < LIM_C;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            mem[r_addr[AW-1:0]] <= r_wr_entry;
        end
        r_rd <= mem[r_cur[AW-1:0]];
    end

    // frame step
    always_comb begin
        if (r_frame_count == '0) begin
            n_cnt = COUNT_W'(1);
        end else if (r_frame_count > LIM_C) begin
            n_cnt = LIM_C;
        end else begin
            n_cnt = r_frame_count;
        end
        sum    = (TW+1)'(r_time) + (TW+1)'(r_elapsed);
        sat    = (sum > TMAX) ? TMAX : sum;
        expire = sat >= (TW+1)'(r_rd.delay);
        at_end = r_back ? (r_cur == '0) : (({1'b0, r_cur} + 1'b1) >= n_cnt);
        n_cur  = r_cur;
        n_back = r_back;
        n_time = sat[TIME_BITS-1:0];
        if (expire) begin
            n_time = '0;
            if (at_end) begin
                if (r_ping_pong) begin
                    if (n_cnt < COUNT_W'(2)) begin
                        n_cur  = '0;
                        n_back = 1'b0;
                    end else if (!r_back) begin
                        n_cur  = FRAME_W'(n_cnt - COUNT_W'(2));
                        n_back = 1'b1;
                    end else begin
                        n_cur  = FRAME_W'(1);
                        n_back = 1'b0;
                    end
                end else begin
                    n_cur = '0;
                end
            end else begin
                n_cur = r_back ? r_cur - 1'b1 : r_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_cur   <= '0;
            r_back  <= 1'b0;
            r_shown <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_done <= 1'b0;
            end else if (i_cmd.step) begin
                r_time <= n_time;
                r_cur  <= n_cur;
                r_back <= n_back;
                r_done <= expire && at_end;
            end
            if (i_cmd.alpha) begin
                if (r_trivial) begin
                    r_shown <= r_s;
                end else if (r_up) begin
                    r_shown <= r_s + quot;
                end else begin
                    r_shown <= r_s - quot;
                end
            end
        end
    end

    // interpolation terms
    always_comb begin
        s_sel = r_back ? r_rd.alpha_end : r_rd.alpha_start;
        e_sel = r_back ? r_rd.alpha_start : r_rd.alpha_end;
        diff  = (s_sel >= e_sel) ? s_sel - e_sel : e_sel - s_sel;
        t_ext = TW'(r_time);
        t_cl  = (t_ext > TW'(r_rd.delay)) ? r_rd.delay : t_ext[DELAY_W-1:0];
        prod  = PROD_W'(diff) * PROD_W'(t_cl);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_s       <= s_sel;
            r_up      <= s_sel < e_sel;
            r_trivial <= (r_rd.delay == '0) || (s_sel == e_sel);
            r_dvs     <= r_rd.delay;
        end
    end

    sfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.mul),
        .i_dividend (prod),
        .i_step     (i_cmd.div_step),
        .i_divisor  (r_dvs),
        .o_quot     (quot),
        .o_last     (div_last)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_frame <= r_cur;
            r_out_alpha <= r_shown;
            r_out_done  <= r_done;
            r_out_back  <= r_back;
        end
    end

    always_comb begin
        o_status.req_load = r_req_type == REQ_LOAD;
        o_status.enable   = r_enable;
        o_status.div_last = div_last;
        o_status.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid            = r_out_valid;
    assign o_frame_index      = r_out_frame;
    assign o_alpha            = r_out_alpha;
    assign o_cycle_done       = r_out_done;
    assign o_running_backward = r_out_back;

    `SFS_ASSERT(a_cur_in_range, i_clk, i_rst_n, {1'b0, r_cur} < LIM_C, "sfs_dp: frame out of range")
    `SFS_ASSERT(a_done_clears_time, i_clk, i_rst_n, r_done |-> (r_time == '0), "sfs_dp: done without time clear")

endmodule

[src/sfs_ctrl.sv]
// Controller state machine: sequences load, frame step, multiply, divide and result hand-off.
// Depends on sfs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  sfs_pkg::t_status i_status,
    output sfs_pkg::t_cmd    o_cmd
);
    import sfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_LOAD;
            ST_LOAD: begin
                if (i_status.req_load) begin
                    n_state = ST_OUT;
                end else if (i_status.enable) begin
                    n_state = ST_RD_CUR;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_RD_CUR: n_state = ST_STEP;
            ST_STEP:   n_state = ST_RD_NEW;
            ST_RD_NEW: n_state = ST_MUL;
            ST_MUL:    n_state = ST_DIV;
            ST_DIV:    if (i_status.div_last) n_state = ST_ALPHA;
            ST_ALPHA:  n_state = ST_OUT;
            ST_OUT:    if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            ST_LOAD:   o_cmd.write    = i_status.req_load;
            ST_STEP:   o_cmd.step     = 1'b1;
            ST_MUL:    o_cmd.mul      = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_ALPHA:  o_cmd.alpha    = 1'b1;
            ST_OUT:    o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    `SFS_ASSERT(a_div_exit, i_clk, i_rst_n, (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_ALPHA), "sfs_ctrl: divide did not finish")

endmodule

[src/sprite_frame_sequencer_alpha_fade_core.sv]
// Top level of the sprite frame sequencer with per-frame alpha fade.
// Depends on sfs_pkg, sfs_ctrl, sfs_dp (with sfs_div).
//
//  channel  direction  handshake               payload
//  in       input      i_valid / o_stall       i_req_type i_elapsed_ms i_frame_addr
//                                              i_frame_delay i_alpha_start i_alpha_end
//  out      output     o_valid / i_stall       o_frame_index o_alpha o_cycle_done
//                                              o_running_backward
//  cfg      input      i_cfg_we                i_cfg_addr i_cfg_wdata
//
// A load or disabled tick goes from accept through LOAD to OUT; an enabled tick also
// passes RD_CUR, STEP, RD_NEW, MUL, DIV (bit-serial, one quotient bit per cycle), ALPHA.
// One transaction is in flight at a time; the next is accepted once the result sits
// in the output register. Reset is synchronous and clears control and sequencer state;
// the frame table holds no reset value. A stall on the output holds the result register.
module sprite_frame_sequencer_alpha_fade_core #(
    parameter int MAX_FRAMES = sfs_pkg::DEF_MAX_FRAMES,
    parameter int TIME_BITS  = sfs_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [sfs_pkg::ELAPSED_W-1:0]  i_elapsed_ms,
    input  logic [sfs_pkg::ADDR_W-1:0]     i_frame_addr,
    input  logic [sfs_pkg::DELAY_W-1:0]    i_frame_delay,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha_start,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sfs_pkg::FRAME_W-1:0]    o_frame_index,
    output logic [sfs_pkg::ALPHA_W-1:0]    o_alpha,
    output logic                           o_cycle_done,
    output logic                           o_running_backward
);
    import sfs_pkg::*;

    t_cmd    cmd;
    t_status status;

    sfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sfs_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_type         (i_req_type),
        .i_elapsed_ms       (i_elapsed_ms),
        .i_frame_addr       (i_frame_addr),
        .i_frame_delay      (i_frame_delay),
        .i_alpha_start      (i_alpha_start),
        .i_alpha_end        (i_alpha_end),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_frame_index      (o_frame_index),
        .o_alpha            (o_alpha),
        .o_cycle_done       (o_cycle_done),
        .o_running_backward (o_running_backward)
    );

endmodule

[sim/sfs_anim_checker.sv]
`timescale 1ns / 100ps
// Transaction checker for the sprite frame sequencer: tracks register writes and
// accepted requests, predicts frame, alpha and direction, compares each result.
// Depends on sfs_pkg.
module sfs_anim_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_req_type,
    input  logic [sfs_pkg::ELAPSED_W-1:0]  i_elapsed_ms,
    input  logic [sfs_pkg::ADDR_W-1:0]     i_frame_addr,
    input  logic [sfs_pkg::DELAY_W-1:0]    i_frame_delay,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha_start,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha_end,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [sfs_pkg::FRAME_W-1:0]    i_frame_index,
    input  logic [sfs_pkg::ALPHA_W-1:0]    i_alpha,
    input  logic                           i_cycle_done,
    input  logic                           i_running_backward,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_cycle_ends
);
    import sfs_pkg::*;

    localparam int unsigned TIME_MAX = (1 << DEF_TIME_BITS) - 1;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [ALPHA_W-1:0] alpha;
        logic               done;
        logic               backward;
    } t_view;

    t_view shown_q[$];

    logic                     anim_en;
    logic [COUNT_W-1:0]       anim_count;
    logic                     anim_pp;

    logic [DEF_TIME_BITS-1:0] time_ms;
    logic [FRAME_W-1:0]       frame;
    logic                     back;
    logic [ALPHA_W-1:0]       alpha_now;
    logic [DELAY_W-1:0]       delay_tbl[TABLE_DEPTH];
    logic [ALPHA_W-1:0]       start_tbl[TABLE_DEPTH];
    logic [ALPHA_W-1:0]       end_tbl[TABLE_DEPTH];

    int fails;
    int checked;
    int cycle_ends;

    function automatic logic [ALPHA_W-1:0] fade_alpha();
        int unsigned s, e, d, t;
        s = 32'(back ? end_tbl[frame] : start_tbl[frame]);
        e = 32'(back ? start_tbl[frame] : end_tbl[frame]);
        d = 32'(delay_tbl[frame]);
        t = 32'(time_ms);
        if (d == 0 || s == e) return ALPHA_W'(s);
        if (t > d) t = d;
        if (s < e) return ALPHA_W'(s + (e - s) * t / d);
        return ALPHA_W'(s - (s - e) * t / d);
    endfunction

    function automatic t_view apply_item(logic req, logic [ELAPSED_W-1:0] el,
                                         logic [ADDR_W-1:0] addr, logic [DELAY_W-1:0] dl,
                                         logic [ALPHA_W-1:0] a_s, logic [ALPHA_W-1:0] a_e);
        t_view       v;
        int unsigned n;
        int unsigned sum;
        logic        hit_end;
        v.done = 1'b0;
        if (req == REQ_LOAD) begin
            if (addr < DEF_MAX_FRAMES) begin
                delay_tbl[addr] = dl;
                start_tbl[addr] = a_s;
                end_tbl[addr]   = a_e;
            end
        end else if (anim_en) begin
            n = 32'(anim_count);
            if (n == 0) n = 1;
            if (n > DEF_MAX_FRAMES) n = DEF_MAX_FRAMES;
            sum = int'(time_ms) + int'(el);
            time_ms = (sum > TIME_MAX) ? TIME_MAX[DEF_TIME_BITS-1:0] : sum[DEF_TIME_BITS-1:0];
            if (time_ms >= delay_tbl[frame]) begin
                hit_end = back ? (frame == 0) : (int'(frame) + 1 >= n);
                if (hit_end) begin
                    if (anim_pp) begin
                        if (n < 2) begin
                            frame = '0;
                            back  = 1'b0;
                        end else if (!back) begin
                            frame = FRAME_W'(n - 2);
                            back  = 1'b1;
                        end else begin
                            frame = FRAME_W'(1);
                            back  = 1'b0;
                        end
                    end else begin
                        frame = '0;
                    end
                    v.done = 1'b1;
                end else begin
                    frame = back ? frame - 1'b1 : frame + 1'b1;
                end
                time_ms = '0;
            end
            alpha_now = fade_alpha();
        end
        v.frame    = frame;
        v.alpha    = alpha_now;
        v.backward = back;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_view got;
        t_view want;
        if (!i_rst_n) begin
            anim_en    = 1'b1;
            anim_count = COUNT_W'(1);
            anim_pp    = 1'b0;
            time_ms    = '0;
            frame      = '0;
            back       = 1'b0;
            alpha_now  = '0;
            shown_q.delete();
            fails      = 0;
            checked    = 0;
            cycle_ends = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ENABLE:      anim_en    = i_cfg_wdata[0];
                    CFG_FRAME_COUNT: anim_count = i_cfg_wdata[COUNT_W-1:0];
                    CFG_PING_PONG:   anim_pp    = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.frame    = i_frame_index;
                got.alpha    = i_alpha;
                got.done     = i_cycle_done;
                got.backward = i_running_backward;
                checked++;
                if (got.done === 1'b1) cycle_ends++;
                if (shown_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result frame %0d alpha %0d done %0b back %0b",
                                 $time, got.frame, got.alpha, got.done, got.backward);
                end else begin
                    want = shown_q.pop_front();
                    if (got.frame !== want.frame || got.alpha !== want.alpha ||
                        got.done !== want.done || got.backward !== want.backward) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch exp frame %0d alpha %0d done %0b back %0b, %s",
                                     $time, want.frame, want.alpha, want.done, want.backward,
                                     $sformatf("got frame %0d alpha %0d done %0b back %0b",
                                               got.frame, got.alpha, got.done, got.backward));
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                shown_q.insert(shown_q.size(),
                               apply_item(i_req_type, i_elapsed_ms, i_frame_addr,
                                          i_frame_delay, i_alpha_start, i_alpha_end));
        end
        o_mismatches <= fails;
        o_pending    <= shown_q.size();
        o_checked    <= checked;
        o_cycle_ends <= cycle_ends;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for sprite_frame_sequencer_alpha_fade_core: clock, reset, register
// phases, load/tick stimulus with random idling, verdict. Depends on sfs_pkg, sfs_anim_checker.
module tb;
    import sfs_pkg::*;

    localparam int                   PHASE_ITEMS = 200;
    localparam int                   NUM_PHASES  = 10;
    localparam int                   CALM_PHASE  = 4;
    localparam int                   HOLD_PHASE  = 3;
    localparam int                   IDLE_GUARD  = 20;
    localparam int                   STUCK_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic               en;
        logic [COUNT_W-1:0] count;
        logic               pp;
    } t_setting;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  req_type = REQ_TICK;
    logic [ELAPSED_W-1:0]  elapsed_ms = '0;
    logic [ADDR_W-1:0]     frame_addr = '0;
    logic [DELAY_W-1:0]    frame_delay = '0;
    logic [ALPHA_W-1:0]    alpha_start = '0;
    logic [ALPHA_W-1:0]    alpha_end = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [FRAME_W-1:0]    frame_index;
    logic [ALPHA_W-1:0]    alpha;
    logic                  cycle_done;
    logic                  running_backward;
    logic                  calm = 1'b0;

    int mismatches;
    int pending;
    int checked;
    int cycle_ends;
    int ticks_sent = 0;
    int loads_sent = 0;
    int settings_used = 0;
    int stuck_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    sprite_frame_sequencer_alpha_fade_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_addr         (cfg_addr),
        .i_cfg_wdata        (cfg_wdata),
        .i_valid            (in_valid),
        .o_stall            (in_stall),
        .i_req_type         (req_type),
        .i_elapsed_ms       (elapsed_ms),
        .i_frame_addr       (frame_addr),
        .i_frame_delay      (frame_delay),
        .i_alpha_start      (alpha_start),
        .i_alpha_end        (alpha_end),
        .o_valid            (out_valid),
        .i_stall            (out_stall),
        .o_frame_index      (frame_index),
        .o_alpha            (alpha),
        .o_cycle_done       (cycle_done),
        .o_running_backward (running_backward)
    );

    sfs_anim_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_addr         (cfg_addr),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_req_type         (req_type),
        .i_elapsed_ms       (elapsed_ms),
        .i_frame_addr       (frame_addr),
        .i_frame_delay      (frame_delay),
        .i_alpha_start      (alpha_start),
        .i_alpha_end        (alpha_end),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_frame_index      (frame_index),
        .i_alpha            (alpha),
        .i_cycle_done       (cycle_done),
        .i_running_backward (running_backward),
        .o_mismatches       (mismatches),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_cycle_ends       (cycle_ends)
    );

    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // valid stays high after a transaction; it is lowered only for a gap or a drain
    task automatic send_item(logic req, logic [ELAPSED_W-1:0] el, logic [ADDR_W-1:0] addr,
                             logic [DELAY_W-1:0] dl, logic [ALPHA_W-1:0] a_s,
                             logic [ALPHA_W-1:0] a_e);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 31) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        elapsed_ms  <= el;
        frame_addr  <= addr;
        frame_delay <= dl;
        alpha_start <= a_s;
        alpha_end   <= a_e;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (req == REQ_LOAD) loads_sent++;
        else ticks_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic apply_setting(t_setting s);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ENABLE;
        cfg_wdata <= CFG_DATA_W'(s.en);
        @(posedge i_clk);
        cfg_addr  <= CFG_FRAME_COUNT;
        cfg_wdata <= s.count;
        @(posedge i_clk);
        cfg_addr  <= CFG_PING_PONG;
        cfg_wdata <= CFG_DATA_W'(s.pp);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin
        t_setting                plan[NUM_PHASES];
        logic [DELAY_W-1:0]      dl;
        logic [ALPHA_W-1:0]      a_s;
        logic [ALPHA_W-1:0]      a_e;
        logic [ELAPSED_W-1:0]    el;
        int                      r;

        plan = '{
            '{1'b1, 5'd1,  1'b0}, '{1'b1, 5'd16, 1'b1}, '{1'b1, 5'd2,  1'b1},
            '{1'b0, 5'd5,  1'b1}, '{1'b1, 5'd0,  1'b1}, '{1'b1, 5'd31, 1'b0},
            '{1'b1, 5'd20, 1'b1}, '{1'b1, 5'd3,  1'b0}, '{1'b1, 5'd1,  1'b1},
            '{1'b1, 5'd16, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // every table entry is loaded before the first tick
        for (int a = 0; a < TABLE_DEPTH; a++) begin
            case (a)
                0:       send_item(REQ_LOAD, '0, ADDR_W'(a), 16'd0, 8'd0, 8'd255);
                1:       send_item(REQ_LOAD, '1, ADDR_W'(a), 16'hFFFF, 8'd255, 8'd0);
                2:       send_item(REQ_LOAD, '0, ADDR_W'(a), 16'd1, 8'd77, 8'd77);
                default: send_item(REQ_LOAD, '0, ADDR_W'(a), DELAY_W'($urandom_range(1, 200)),
                                   ALPHA_W'($urandom), ALPHA_W'($urandom));
            endcase
        end
        send_item(REQ_TICK, 16'd0, '0, '0, '0, '0);
        send_item(REQ_TICK, 16'hFFFF, '1, '1, '1, '1);
        wait_idle();
        apply_setting(plan[1]);
        repeat (5) send_item(REQ_TICK, 16'hFFFF, '0, '0, '0, '0);
        send_item(REQ_TICK, 16'd1, '0, '0, '0, '0);
        send_item(REQ_LOAD, '0, ADDR_W'(5), 16'd0, 8'd200, 8'd10);
        wait_idle();

        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(plan[p]);
            calm <= (p == CALM_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == HOLD_PHASE && k == PHASE_ITEMS / 2) wait_idle();
                if ($urandom_range(0, 3) == 0) begin
                    r = $urandom_range(0, 9);
                    dl = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? DELAY_W'($urandom) :
                         DELAY_W'($urandom_range(1, 120));
                    a_s = ALPHA_W'($urandom);
                    a_e = ($urandom_range(0, 7) == 0) ? a_s : ALPHA_W'($urandom);
                    send_item(REQ_LOAD, ELAPSED_W'($urandom), ADDR_W'($urandom), dl, a_s, a_e);
                end else begin
                    r = $urandom_range(0, 9);
                    el = (r == 0) ? '0 : (r == 1) ? ELAPSED_W'($urandom) :
                         ELAPSED_W'($urandom_range(0, 60));
                    send_item(REQ_TICK, el, ADDR_W'($urandom), DELAY_W'($urandom),
                              ALPHA_W'($urandom), ALPHA_W'($urandom));
                end
            end
            wait_idle();
        end

        $display("Covered %0d ticks and %0d frame loads over %0d register settings;",
                 ticks_sent, loads_sent, settings_used);
        $display("%0d results checked, %0d sequence ends seen.", checked, cycle_ends);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
